// ----- hdl/frac_pkg.sv -----
// ---------------------------------------------------------------------------
// frac_pkg
// Shared constants and types for the fraction reducer.
// ---------------------------------------------------------------------------
package frac_pkg;

   localparam int DEFAULT_WIDTH = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TWOS,
      S_LOOP,
      S_DIV_N,
      S_DIV_D,
      S_DONE
   } state_type;

endpackage

// ----- hdl/frac_req_if.sv -----
// ---------------------------------------------------------------------------
// frac_req_if
// Request channel: one fraction (numerator, denominator) per transfer.
// ---------------------------------------------------------------------------
interface frac_req_if #(
   parameter int WIDTH = frac_pkg::DEFAULT_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] numerator;
   logic [WIDTH-1:0] denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// ----- hdl/frac_rsp_if.sv -----
// ---------------------------------------------------------------------------
// frac_rsp_if
// Response channel: one reduced fraction and its valid flag per transfer.
// ---------------------------------------------------------------------------
interface frac_rsp_if #(
   parameter int WIDTH = frac_pkg::DEFAULT_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] reduced_numerator;
   logic [WIDTH-1:0] reduced_denominator;
   logic             valid_res;

   modport source (
      output valid, output reduced_numerator, output reduced_denominator,
      output valid_res, input ready
   );
   modport sink (
      input valid, input reduced_numerator, input reduced_denominator,
      input valid_res, output ready
   );
endinterface

// ----- hdl/fraction_reducer.sv -----
// ---------------------------------------------------------------------------
// fraction_reducer
// Reduces numerator/denominator to lowest terms with one shared subtractor.
//
// Usage:
//   req_if (sink) takes one fraction per transfer; req_if.ready is high only
//   while the sequencer is idle, so one fraction is in work at a time.
//   rsp_if (source) returns one result per request: both values divided by
//   their greatest common divisor and valid_res = 1. Both inputs zero give
//   0/0 with valid_res = 0; a zero numerator gives 0/1.
//   Sequence: the common factors of two are stripped first, then binary GCD
//   takes one step per cycle (halve, swap or subtract) until a value reaches
//   zero, then two restoring divisions through the same subtractor give the
//   two quotients, and then the output register is loaded.
//   Both zero: the sequencer skips the GCD and the divisions and goes
//   straight to loading the output register.
//   The subtractor sets the rate.
//   The result waits in an output register; the next request is taken while
//   it waits, and a finished result that cannot be placed holds the
//   sequencer until the receiver takes the waiting one.
//   Reset (synchronous, active high) empties the output register and
//   returns the sequencer to idle.
// ---------------------------------------------------------------------------
module fraction_reducer #(
   parameter int WIDTH = frac_pkg::DEFAULT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   frac_req_if.sink    req_if,
   frac_rsp_if.source  rsp_if
);

   localparam int KW = $clog2(WIDTH);

   frac_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-1:0] quo_n_ff, quo_n_in;
   logic [WIDTH-1:0] quo_d_ff, quo_d_in;
   logic             ok_ff, ok_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [KW-1:0]    cnt_ff, cnt_in;

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_num_ff, out_num_in;
   logic [WIDTH-1:0] out_den_ff, out_den_in;
   logic             out_ok_ff, out_ok_in;

   logic             dividing;
   logic [WIDTH:0]   sub_a, sub_b;
   logic [WIDTH+1:0] diff;
   logic             borrow;
   logic [WIDTH-1:0] q_step, rem_step;

   assign dividing = (state_ff == frac_pkg::S_DIV_N) || (state_ff == frac_pkg::S_DIV_D);
   assign sub_a    = dividing ? {rem_ff, q_ff[WIDTH-1]} : {1'b0, a_ff};
   assign sub_b    = dividing ? {1'b0, g_ff} : {1'b0, b_ff};
   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow   = diff[WIDTH+1];
   assign q_step   = {q_ff[WIDTH-2:0], ~borrow};
   assign rem_step = borrow ? sub_a[WIDTH-1:0] : diff[WIDTH-1:0];

   assign req_if.ready               = (state_ff == frac_pkg::S_IDLE);
   assign rsp_if.valid               = out_valid_ff;
   assign rsp_if.reduced_numerator   = out_num_ff;
   assign rsp_if.reduced_denominator = out_den_ff;
   assign rsp_if.valid_res           = out_ok_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      quo_n_in     = quo_n_ff;
      quo_d_in     = quo_d_ff;
      ok_in        = ok_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_ok_in    = out_ok_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         frac_pkg::S_IDLE: begin
            if (req_if.valid) begin
               n_in  = req_if.numerator;
               d_in  = req_if.denominator;
               a_in  = req_if.numerator;
               b_in  = req_if.denominator;
               k_in  = '0;
               if (req_if.numerator == '0 && req_if.denominator == '0) begin
                  quo_n_in = '0;
                  quo_d_in = '0;
                  ok_in    = 1'b0;
                  state_in = frac_pkg::S_DONE;
               end else begin
                  ok_in    = 1'b1;
                  state_in = frac_pkg::S_TWOS;
               end
            end
         end
         frac_pkg::S_TWOS: begin
            if (a_ff == '0 || b_ff == '0 || a_ff[0] || b_ff[0]) begin
               state_in = frac_pkg::S_LOOP;
            end else begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         frac_pkg::S_LOOP: begin
            if (a_ff == '0 || b_ff == '0) begin
               g_in     = (a_ff == '0) ? (b_ff << k_ff) : (a_ff << k_ff);
               rem_in   = '0;
               q_in     = n_ff;
               cnt_in   = KW'(WIDTH - 1);
               state_in = frac_pkg::S_DIV_N;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (borrow) begin
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = diff[WIDTH-1:0];
            end
         end
         frac_pkg::S_DIV_N: begin
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               quo_n_in = q_step;
               rem_in   = '0;
               q_in     = d_ff;
               cnt_in   = KW'(WIDTH - 1);
               state_in = frac_pkg::S_DIV_D;
            end
         end
         frac_pkg::S_DIV_D: begin
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               quo_d_in = q_step;
               state_in = frac_pkg::S_DONE;
            end
         end
         frac_pkg::S_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_num_in   = quo_n_ff;
               out_den_in   = quo_d_ff;
               out_ok_in    = ok_ff;
               out_valid_in = 1'b1;
               state_in     = frac_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = frac_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frac_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      quo_n_ff   <= quo_n_in;
      quo_d_ff   <= quo_d_in;
      ok_ff      <= ok_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_ok_ff  <= out_ok_in;
   end

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while a fraction is in work");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frac_pkg::S_DIV_N || state_ff == frac_pkg::S_DIV_D) |-> g_ff != '0)
      else $error("division started with a zero divisor");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.valid_res |->
         rsp_if.reduced_numerator == '0 && rsp_if.reduced_denominator == '0)
      else $error("invalid result carries nonzero values");

   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.valid_res |->
         rsp_if.reduced_numerator != '0 || rsp_if.reduced_denominator != '0)
      else $error("valid result is 0/0");

endmodule

// ----- verif/fraction_reduction_check.sv -----
// ---------------------------------------------------------------------------
// fraction_reduction_check
// Watches the request and response channels of the fraction reducer. Each
// request transfer is reduced to lowest terms by Euclid's algorithm here and
// queued. Each response transfer is compared field by field with the oldest
// queued fraction. Mismatches and unexpected responses are counted.
// ---------------------------------------------------------------------------
module fraction_reduction_check #(
   parameter int WIDTH = frac_pkg::DEFAULT_WIDTH
) (
   input  logic clock,
   input  logic reset,
   frac_req_if  req,
   frac_rsp_if  rsp,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WIDTH-1:0] num;
      logic [WIDTH-1:0] den;
      logic             ok;
   } lowest_terms_type;

   lowest_terms_type reduced_q[$];

   function automatic lowest_terms_type reduce_fraction(input logic [WIDTH-1:0] n,
                                                        input logic [WIDTH-1:0] d);
      lowest_terms_type r;
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic [WIDTH-1:0] t;
      r = '0;
      if (n == '0 && d == '0) begin
         return r;
      end
      a = n;
      b = d;
      while (b != '0) begin
         t = a % b;
         a = b;
         b = t;
      end
      r.num = n / a;
      r.den = d / a;
      r.ok  = 1'b1;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [WIDTH-1:0] got,
                                input logic [WIDTH-1:0] want);
      $display("%0t: mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      lowest_terms_type want;
      if (!reset) begin
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            reduced_q.push_back(reduce_fraction(req.numerator, req.denominator));
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (reduced_q.size() == 0) begin
               flag_mismatch("unexpected transfer", rsp.reduced_numerator, '0);
            end else begin
               want = reduced_q.pop_front();
               if (rsp.reduced_numerator !== want.num) begin
                  flag_mismatch("reduced_numerator", rsp.reduced_numerator, want.num);
               end
               if (rsp.reduced_denominator !== want.den) begin
                  flag_mismatch("reduced_denominator", rsp.reduced_denominator,
                                want.den);
               end
               if (rsp.valid_res !== want.ok) begin
                  flag_mismatch("valid_res", WIDTH'(rsp.valid_res), WIDTH'(want.ok));
               end
            end
         end
      end
      pending_count = reduced_q.size();
   end

endmodule

// ----- verif/fraction_reducer_tb.sv -----
// ---------------------------------------------------------------------------
// fraction_reducer_tb
// Drives directed and random fractions into the fraction reducer with random
// idle cycles on both channels, and lets the checker compare every response
// with a lowest-terms prediction. Prints the verdict at the end of the run.
// ---------------------------------------------------------------------------
module fraction_reducer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W            = frac_pkg::DEFAULT_WIDTH;
   localparam int RANDOM_ITEMS = 1930;
   localparam int DRAIN_CYCLES = 400;

   logic clock;
   logic reset;
   logic steady;
   int   fail_count;
   int   pending_count;

   frac_req_if #(.WIDTH(W)) req_ch ();
   frac_rsp_if #(.WIDTH(W)) rsp_ch ();

   fraction_reducer #(.WIDTH(W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   fraction_reduction_check #(.WIDTH(W)) lowest_terms_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 17);
   end

   task automatic push_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
      while (!steady && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.numerator   <= n;
      req_ch.denominator <= d;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   function automatic logic [W-1:0] scaled(input logic [W-1:0] g);
      return g * W'($urandom_range(0, 32'hFFFF_FFFF / g));
   endfunction

   initial begin
      logic [W-1:0] g;
      logic [W-1:0] n;
      logic [W-1:0] d;
      int           kind;
      reset              <= 1'b1;
      steady             <= 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.numerator   <= '0;
      req_ch.denominator <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero cases, extremes, powers of two, worst-case Euclid pair
      push_fraction('0, '0);
      push_fraction('0, 32'd1);
      push_fraction('0, '1);
      push_fraction(32'd1, '0);
      push_fraction('1, '0);
      push_fraction(32'd1, 32'd1);
      push_fraction('1, '1);
      push_fraction('1, 32'd1);
      push_fraction(32'd1, '1);
      push_fraction('1, 32'hFFFF_FFFE);
      push_fraction(32'h8000_0000, 32'h4000_0000);
      push_fraction(32'h8000_0000, 32'h8000_0000);
      push_fraction(32'h8000_0000, 32'd1);
      push_fraction(32'd12, 32'd18);
      push_fraction(32'd2971215073, 32'd1836311903);
      push_fraction(32'd1836311903, 32'd2971215073);
      push_fraction(32'd4294967291, 32'd4294967279);
      push_fraction(32'hAAAA_AAAA, 32'h5555_5555);
      push_fraction(32'd65536 * 32'd65521, 32'd65521 * 32'd3);
      push_fraction(32'd7, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 900) steady <= 1'b1;
         if (i == 1250) steady <= 1'b0;
         kind = $urandom_range(99);
         if (kind < 30) begin
            g = W'($urandom_range(1, 65535));
            if ($urandom_range(3) == 0) g = W'(1) << $urandom_range(0, 20);
            n = scaled(g);
            d = scaled(g);
         end else if (kind < 40) begin
            n = W'($urandom_range(1, 255)) << $urandom_range(0, 24);
            d = W'($urandom_range(1, 255)) << $urandom_range(0, 24);
         end else if (kind < 48) begin
            n = '0;
            d = $urandom;
            if ($urandom_range(1)) begin
               n = d;
               d = '0;
            end
         end else if (kind < 50) begin
            n = '0;
            d = '0;
         end else if (kind < 60) begin
            n = W'($urandom_range(0, 255));
            d = W'($urandom_range(0, 255));
         end else begin
            n = $urandom;
            d = $urandom;
         end
         push_fraction(n, d);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("fraction_reducer_tb OK");
      end else begin
         $display("fraction_reducer_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("fraction_reducer_tb NOT OK");
      $finish;
   end

endmodule
